[hdl/sgs_pkg.sv]
// Shared types and constants for the sixteen-step gate sequencer.
package sgs_pkg;

  localparam int unsigned ButtonW   = 16;
  localparam int unsigned PhaseInW  = 24;
  localparam int unsigned StepOutW  = 4;
  localparam int unsigned StepCntW  = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 5;

  localparam logic [StepCntW-1:0] StepCountRst = 5'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEP_COUNT = 2'd0,
    CFG_EXT_MODE   = 2'd1
  } sgs_cfg_idx_e;

  typedef struct packed {
    logic [StepCntW-1:0] step_count;
    logic                external_clock_mode;
  } sgs_cfg_t;

  typedef struct packed {
    logic                run_level;
    logic                restart_level;
    logic                ext_clock_level;
    logic [ButtonW-1:0]  gate_buttons;
    logic [PhaseInW-1:0] phase_increment;
  } sgs_in_t;

  typedef struct packed {
    logic [StepOutW-1:0] current_step;
    logic [ButtonW-1:0]  step_gate_mask;
    logic                combined_gate;
    logic                is_running;
    logic                advanced;
  } sgs_out_t;

endpackage

[hdl/sgs_cfg_regs.sv]
// Configuration register file: step count and clock source select.
module sgs_cfg_regs import sgs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output sgs_cfg_t            cfg_o
);

  sgs_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_STEP_COUNT: cfg_d.step_count = cfg_data_i[StepCntW-1:0];
        CFG_EXT_MODE:   cfg_d.external_clock_mode = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_count          <= StepCountRst;
      cfg_q.external_clock_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[hdl/sgs_step_core.sv]
// Sequencer state, single-pass next-state logic and the result register.
module sgs_step_core import sgs_pkg::*; #(
  parameter int unsigned MAX_STEPS  = 16,
  parameter int unsigned PHASE_BITS = 24
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  sgs_cfg_t cfg_i,
  input  sgs_in_t  item_i,
  output sgs_out_t result_o
);

  localparam int unsigned IdxW  = $clog2(MAX_STEPS);
  localparam int unsigned CntW  = ($clog2(MAX_STEPS + 1) > StepCntW) ?
                                  $clog2(MAX_STEPS + 1) : StepCntW;
  localparam int unsigned PadW  = IdxW + StepOutW;

  logic                  running_q, running_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [MAX_STEPS-1:0]  gates_q, gates_d;
  logic [2:0]            prev_ctl_q;
  logic [MAX_STEPS-1:0]  prev_btn_q;
  sgs_out_t              result_q, result_d;

  logic [2:0]                      ctl;
  logic [2:0]                      ctl_rise;
  logic [MAX_STEPS+ButtonW-1:0]    btn_pad;
  logic [MAX_STEPS-1:0]            btn;
  logic [PHASE_BITS+PhaseInW-1:0]  inc_pad;
  logic [PHASE_BITS-1:0]           inc;
  logic [PHASE_BITS:0]             sum;
  logic [CntW-1:0]                 sc;
  logic [CntW-1:0]                 n_steps;
  logic                            next;
  logic                            gate_on;
  logic [PadW-1:0]                 idx_pad;

  assign ctl      = {item_i.ext_clock_level, item_i.restart_level, item_i.run_level};
  assign ctl_rise = ctl & ~prev_ctl_q;
  assign btn_pad  = {{MAX_STEPS{1'b0}}, item_i.gate_buttons};
  assign btn      = btn_pad[MAX_STEPS-1:0];
  assign inc_pad  = {{PHASE_BITS{1'b0}}, item_i.phase_increment};
  assign inc      = inc_pad[PHASE_BITS-1:0];
  assign sum      = {1'b0, phase_q} + {1'b0, inc};
  assign sc       = CntW'(cfg_i.step_count);

  always_comb begin
    if (sc == '0) begin
      n_steps = CntW'(1);
    end else if (sc > CntW'(MAX_STEPS)) begin
      n_steps = CntW'(MAX_STEPS);
    end else begin
      n_steps = sc;
    end
  end

  always_comb begin
    running_d = running_q ^ ctl_rise[0];
    phase_d   = phase_q;
    next      = 1'b0;

    // The clock only counts with the running flag as updated on this transaction.
    if (running_d) begin
      if (cfg_i.external_clock_mode) begin
        if (ctl_rise[2]) begin
          phase_d = '0;
          next    = 1'b1;
        end
      end else begin
        phase_d = sum[PHASE_BITS-1:0];
        next    = sum[PHASE_BITS];
      end
    end

    // A restart absorbs any clock advance on the same transaction.
    if (ctl_rise[1]) begin
      phase_d = '0;
      next    = 1'b1;
    end

    idx_d = idx_q;
    if (next) begin
      if (ctl_rise[1] || (CntW'(idx_q) + CntW'(1) >= n_steps)) begin
        idx_d = '0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end

    gates_d = gates_q ^ (btn & ~prev_btn_q);
    gate_on = gates_d[idx_d];
    idx_pad = {{StepOutW{1'b0}}, idx_d};

    result_d.current_step  = idx_pad[StepOutW-1:0];
    for (int i = 0; i < ButtonW; i++) begin
      result_d.step_gate_mask[i] = gate_on && (idx_pad == PadW'(i));
    end
    result_d.combined_gate = gate_on && !next;
    result_d.is_running    = running_d;
    result_d.advanced      = next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b1;
      phase_q    <= '0;
      idx_q      <= '0;
      gates_q    <= '0;
      prev_ctl_q <= '0;
      prev_btn_q <= '0;
    end else if (fire_i) begin
      running_q  <= running_d;
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      gates_q    <= gates_d;
      prev_ctl_q <= ctl;
      prev_btn_q <= btn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

[hdl/sixteen_step_gate_sequencer.sv]
// Top level of the sixteen-step gate sequencer: input register, core and output handshake.
// Path: a transaction is held in the input register, then moves into the result register
// when the pipeline advances, and is offered on the output from there.
// Throughput: one transaction per cycle unless the output stalls; the input and result
// registers hold one item each, so one more is taken while a result waits on a stall.
// Reset (rst_ni low, asynchronous): running on, phase, step and gates cleared,
// step count 16, internal clock source; both pipeline registers empty.
module sixteen_step_gate_sequencer import sgs_pkg::*; #(
  parameter int unsigned MAX_STEPS  = 16,
  parameter int unsigned PHASE_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sgs_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sgs_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  sgs_cfg_t cfg;
  sgs_in_t  in_q;
  logic     in_valid_q;
  logic     out_valid_q;
  logic     advance;
  logic     fire;

  // The pipeline moves whenever the result register is empty or being taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = advance && in_valid_q;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  sgs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sgs_step_core #(
    .MAX_STEPS  (MAX_STEPS),
    .PHASE_BITS (PHASE_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .cfg_i    (cfg),
    .item_i   (in_q),
    .result_o (out_data_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

[hdl/sgs_checker.sv]
// Port-level checker for the gate sequencer and its bind to the top level.
module sgs_checker import sgs_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input sgs_out_t out_data_o
);

  // A stalled result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_mute_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.advanced |-> !out_data_o.combined_gate)
    else $error("combined gate open on an advance transaction");

  a_mask_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(out_data_o.step_gate_mask))
    else $error("step gate mask has more than one bit");

  // The mask bit, when present, sits at the reported step.
  a_mask_at_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.step_gate_mask != '0) |->
      out_data_o.step_gate_mask[out_data_o.current_step])
    else $error("step gate mask bit not at current step");

  a_gate_needs_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.combined_gate |-> out_data_o.step_gate_mask != '0)
    else $error("combined gate open with empty mask");

endmodule

bind sixteen_step_gate_sequencer sgs_checker u_sgs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
